// ===== rtl/stream_reassembly_buffer_core_assert.svh =====
`ifndef STREAM_REASSEMBLY_BUFFER_CORE_ASSERT_SVH
`define STREAM_REASSEMBLY_BUFFER_CORE_ASSERT_SVH
// Assertion macros shared by the block's modules.
`ifndef ASSERT_OFF
`define SRB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define SRB_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define SRB_ASSERT(label, clk, rst, prop)
`define SRB_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== rtl/srb_pkg.sv =====
package srb_pkg;
   localparam logic [1:0] OP_MARK = 2'd0;
   localparam logic [1:0] OP_HEADER = 2'd1;
   localparam logic [1:0] OP_BYTE = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;
   localparam logic [7:0] SEQ_PAST_BIT = 8'h80;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  seq_number;
      logic [15:0] start_offset;
      logic [7:0]  stream_length;
      logic [7:0]  data_byte;
   } item_type;
endpackage

// ===== rtl/srb_ram.sv =====
module srb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/srb_front.sv =====
`include "stream_reassembly_buffer_core_assert.svh"

module srb_front import srb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type req_item,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_take
);
   item_type   buf_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wp_ff, rp_ff;
   logic       do_push;

   assign full = count_ff == 2'd2;
   assign do_push = push && !full;
   assign q_valid = count_ff != 2'd0;
   assign q_item = buf_ff[rp_ff];

   always_comb begin
      count_in = count_ff + {1'b0, do_push} - {1'b0, q_take && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) wp_ff <= !wp_ff;
         if (q_take && q_valid) rp_ff <= !rp_ff;
      end
      if (do_push) buf_ff[wp_ff] <= req_item;
   end

   `SRB_ASSERT(a_count_in_range, clock, reset, count_ff != 2'd3)
   `SRB_ASSERT(a_take_only_valid, clock, reset, !q_take || q_valid)
   `SRB_ASSERT_RST(a_queue_empty_after_reset, clock, reset |=> count_ff == 2'd0)
endmodule

// ===== rtl/srb_back.sv =====
`include "stream_reassembly_buffer_core_assert.svh"

module srb_back import srb_pkg::*; #(
   parameter int BUFFER_BYTES = 1024,
   parameter int WINDOW_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_take,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_accepted,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic [10:0] rsp_free_bytes
);
   localparam int SW = $clog2(WINDOW_SLOTS);
   localparam int BW = $clog2(BUFFER_BYTES);
   localparam logic [16:0] BUF_SIZE = 17'(BUFFER_BYTES);
   localparam logic [7:0] SLOTS8 = 8'(WINDOW_SLOTS);
   localparam logic [2:0] ST_POP = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_POST = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_OUT = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [7:0]  head_ff, tail_ff;
   logic [15:0] consumed_ff, contig_ff, highest_ff, wpos_ff;
   logic [7:0]  remaining_ff;
   logic        wen_ff;
   logic [WINDOW_SLOTS-1:0] len_nz_ff, mark_ff;
   logic [15:0] end_ff [WINDOW_SLOTS];
   logic        acc_ff, rv_ff;
   logic [7:0]  rb_ff;
   logic        out_valid_ff;
   logic [10:0] free_now;

   logic [SW-1:0] hidx;
   logic          head_done;
   logic [7:0]    diff, tdiff;
   logic [15:0]   end_off;
   logic          ram_we;
   logic [BW-1:0] ram_waddr;
   logic [7:0]    ram_rdata;
   logic          mark_like;
   logic          hdr_store;

   assign hidx = head_ff[SW-1:0];
   assign head_done = head_ff != tail_ff && (len_nz_ff[hidx] || mark_ff[hidx]);
   assign diff = q_item.seq_number - head_ff;
   assign tdiff = q_item.seq_number - tail_ff;
   assign end_off = q_item.start_offset + {8'd0, q_item.stream_length};
   assign mark_like = q_item.opcode == OP_MARK ||
                      (q_item.opcode == OP_HEADER && q_item.stream_length == 8'd0);
   assign hdr_store = q_item.opcode == OP_HEADER && q_item.stream_length != 8'd0 &&
                      diff < SLOTS8 && {1'b0, end_off - consumed_ff} <= BUF_SIZE;
   assign ram_we = state_ff == ST_EXEC && q_item.opcode == OP_BYTE && wen_ff &&
                   remaining_ff != 8'd0;
   assign ram_waddr = wpos_ff[BW-1:0];
   assign q_take = state_ff == ST_OUT && !out_valid_ff;

   srb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(q_item.data_byte),
      .rd_addr(consumed_ff[BW-1:0]), .rd_data(ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_POP: if (q_valid && !head_done) state_in = ST_EXEC;
         ST_EXEC: state_in = mark_like ? ST_POST :
                             (q_item.opcode == OP_READ ? ST_READ : ST_OUT);
         ST_POST: if (!head_done) state_in = ST_OUT;
         ST_READ: state_in = ST_OUT;
         ST_OUT: if (!out_valid_ff) state_in = ST_POP;
         default: state_in = ST_POP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_POP;
         head_ff <= 8'd0;
         tail_ff <= 8'd0;
         consumed_ff <= 16'd0;
         contig_ff <= 16'd0;
         highest_ff <= 16'd0;
         wpos_ff <= 16'd0;
         remaining_ff <= 8'd0;
         wen_ff <= 1'b0;
         len_nz_ff <= '0;
         mark_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && rsp_pop) out_valid_ff <= 1'b0;
         if ((state_ff == ST_POP && q_valid) || state_ff == ST_POST) begin
            if (head_done) begin
               if (!mark_ff[hidx]) contig_ff <= end_ff[hidx];
               len_nz_ff[hidx] <= 1'b0;
               mark_ff[hidx] <= 1'b0;
               head_ff <= head_ff + 8'd1;
            end
         end
         if (state_ff == ST_POP && q_valid && !head_done) begin
            acc_ff <= 1'b1;
            rv_ff <= 1'b0;
            rb_ff <= 8'd0;
         end
         if (state_ff == ST_EXEC) begin
            if (q_item.opcode == OP_HEADER && !hdr_store) begin
               wen_ff <= 1'b0;
               remaining_ff <= 8'd0;
            end
            if (mark_like) begin
               if (diff < SLOTS8) begin
                  if (tdiff < SLOTS8) tail_ff <= q_item.seq_number + 8'd1;
                  mark_ff[q_item.seq_number[SW-1:0]] <= 1'b1;
                  len_nz_ff[q_item.seq_number[SW-1:0]] <= 1'b0;
               end
            end else if (q_item.opcode == OP_HEADER) begin
               if (diff >= SLOTS8) begin
                  acc_ff <= (diff & SEQ_PAST_BIT) != 8'd0;
               end else if (!hdr_store) begin
                  acc_ff <= 1'b0;
               end else begin
                  if (tdiff < SLOTS8) tail_ff <= q_item.seq_number + 8'd1;
                  if ({1'b0, end_off - highest_ff} < BUF_SIZE) highest_ff <= end_off;
                  len_nz_ff[q_item.seq_number[SW-1:0]] <= 1'b1;
                  mark_ff[q_item.seq_number[SW-1:0]] <= 1'b0;
                  end_ff[q_item.seq_number[SW-1:0]] <= end_off;
                  wpos_ff <= q_item.start_offset;
                  remaining_ff <= q_item.stream_length;
                  wen_ff <= 1'b1;
               end
            end else if (ram_we) begin
               wpos_ff <= wpos_ff + 16'd1;
               remaining_ff <= remaining_ff - 8'd1;
               if (remaining_ff == 8'd1) wen_ff <= 1'b0;
            end
         end
         if (state_ff == ST_READ && contig_ff != consumed_ff) begin
            rv_ff <= 1'b1;
            rb_ff <= ram_rdata;
            consumed_ff <= consumed_ff + 16'd1;
         end
         if (state_ff == ST_OUT && !out_valid_ff) begin
            out_valid_ff <= 1'b1;
            rsp_accepted <= acc_ff;
            rsp_read_valid <= rv_ff;
            rsp_read_byte <= rb_ff;
            rsp_free_bytes <= free_now;
         end
      end
   end

   always_comb begin
      logic [15:0] d;
      d = consumed_ff - highest_ff;
      free_now = (head_ff == tail_ff) ? 11'(BUFFER_BYTES) : 11'(d[BW-1:0]);
   end

   assign rsp_empty = !out_valid_ff;

   `SRB_ASSERT(a_state_legal, clock, reset, state_ff <= ST_OUT)
   `SRB_ASSERT(a_write_budget, clock, reset, wen_ff || remaining_ff == 8'd0)
   `SRB_ASSERT(a_window_span, clock, reset, (tail_ff - head_ff) <= SLOTS8)
   `SRB_ASSERT_RST(a_idle_after_reset, clock, reset |=> state_ff == ST_POP && !out_valid_ff)
endmodule

// ===== rtl/stream_reassembly_buffer_core.sv =====
// Reorders sequence-numbered stream packets into an in-order byte stream. Every
// input transfer yields exactly one result transfer. An item enters the
// two-entry input queue; the execution engine then steps through pop, execute
// and output states, adding a read state for a read and a post state for a mark
// or a zero-length header, and retires each finished window slot at the head in
// the pop or post state. A result not yet popped holds the engine until taken.
module stream_reassembly_buffer_core import srb_pkg::*; #(
   parameter int BUFFER_BYTES = 1024,
   parameter int WINDOW_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_seq_number,
   input  logic [15:0] req_start_offset,
   input  logic [7:0]  req_stream_length,
   input  logic [7:0]  req_data_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_accepted,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic [10:0] rsp_free_bytes
);
   item_type req_item, q_item;
   logic     q_valid, q_take;

   assign req_item = '{req_opcode, req_seq_number, req_start_offset,
                       req_stream_length, req_data_byte};

   srb_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
   );

   srb_back #(.BUFFER_BYTES(BUFFER_BYTES), .WINDOW_SLOTS(WINDOW_SLOTS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .q_take(q_take), .rsp_empty(empty), .rsp_pop(pop),
      .rsp_accepted(rsp_accepted), .rsp_read_valid(rsp_read_valid),
      .rsp_read_byte(rsp_read_byte), .rsp_free_bytes(rsp_free_bytes)
   );
endmodule
